// ===== hw/rtl/dlr_pkg.sv =====
// Shared constants and types for the DDA line rasterizer.
// No dependencies; every file that uses it refers to it by scoped names.
package dlr_pkg;

  localparam int unsigned COLOR_BITS = 4;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Back-end sequencer states, one-hot
  typedef enum logic [1:0] {
    BK_RUN = 2'b01,
    BK_DIV = 2'b10
  } bk_state_e;

endpackage

// ===== hw/rtl/dlr_in_if.sv =====
// Input channel of the line rasterizer: valid/ready plus a command item.
// Depends on dlr_pkg for the colour width.
interface dlr_in_if #(
  parameter int unsigned COORD_BITS = 10
);
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [COORD_BITS-1:0]          x_start;
  logic [COORD_BITS-1:0]          y_start;
  logic [COORD_BITS-1:0]          x_end;
  logic [COORD_BITS-1:0]          y_end;
  logic [dlr_pkg::COLOR_BITS-1:0] color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, color, input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, color, output ready);
endinterface

// ===== hw/rtl/dlr_out_if.sv =====
// Output channel of the line rasterizer: valid/ready plus one pixel result.
// Depends on dlr_pkg for the colour width.
interface dlr_out_if #(
  parameter int unsigned COORD_BITS = 10
);
  logic                           valid;
  logic                           ready;
  logic                           valid_res;
  logic [COORD_BITS-1:0]          pixel_x;
  logic [COORD_BITS-1:0]          pixel_y;
  logic [dlr_pkg::COLOR_BITS-1:0] pixel_color;
  logic                           last;

  modport source (output valid, valid_res, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink   (input valid, valid_res, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// ===== hw/rtl/dda_line_rasterizer.sv =====
// Channel  Dir  Modport        Payload
// in_i     in   dlr_in_if.sink   mode, x_start, y_start, x_end, y_end, color
// out_o    out  dlr_out_if.source valid_res, pixel_x, pixel_y, pixel_color, last
//
// Step items stream through the back end at one per cycle while the output is not stalled.
// A start item emits its first pixel at once; unless its step count is zero, it then holds
// the back end while the bit-serial divider forms both increments.
// A two-entry queue lets the input keep transferring while the back end divides.
// Reset clears the line state; no line is active afterwards.
// A stalled output holds its pixel; the queue absorbs up to two more items.
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlr_in_if.sink    in_i,
  dlr_out_if.source out_o
);

  localparam int unsigned EntryW = 5 * COORD_BITS + 3 + dlr_pkg::COLOR_BITS;

  logic              fe_valid, fe_ready;
  logic [EntryW-1:0] fe_data;
  logic              be_valid, be_ready;
  logic [EntryW-1:0] be_data;

  dlr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_i        (in_i),
    .ent_valid_o (fe_valid),
    .ent_o       (fe_data),
    .ent_ready_i (fe_ready)
  );

  dlr_queue #(.W(EntryW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_data),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_data_o   (be_data)
  );

  dlr_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_valid_i (be_valid),
    .ent_ready_o (be_ready),
    .ent_i       (be_data),
    .out_o       (out_o)
  );

endmodule

// ===== hw/rtl/dlr_front.sv =====
// Front end: takes command transfers and classifies them into queue entries
// (start or step, endpoint deltas, step count). Depends on dlr_pkg, dlr_in_if.
module dlr_front #(
  parameter int unsigned COORD_BITS = 10,
  localparam int unsigned EntryW = 5 * COORD_BITS + 3 + dlr_pkg::COLOR_BITS
) (
  dlr_in_if.sink            in_i,
  output logic              ent_valid_o,
  output logic [EntryW-1:0] ent_o,
  input  logic              ent_ready_i
);

  typedef struct packed {
    logic                           is_start;
    logic [COORD_BITS-1:0]          x0;
    logic [COORD_BITS-1:0]          y0;
    logic [COORD_BITS-1:0]          adx;
    logic [COORD_BITS-1:0]          ady;
    logic [COORD_BITS-1:0]          steps;
    logic                           negx;
    logic                           negy;
    logic [dlr_pkg::COLOR_BITS-1:0] color;
  } entry_t;

  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS:0]   dx_abs, dy_abs;
  entry_t                ent;

  assign dx     = {1'b0, in_i.x_end} - {1'b0, in_i.x_start};
  assign dy     = {1'b0, in_i.y_end} - {1'b0, in_i.y_start};
  assign dx_abs = dx[COORD_BITS] ? ((COORD_BITS+1)'(0) - dx) : dx;
  assign dy_abs = dy[COORD_BITS] ? ((COORD_BITS+1)'(0) - dy) : dy;

  always_comb begin
    ent          = '0;
    ent.is_start = (in_i.mode == dlr_pkg::MODE_START);
    ent.x0       = in_i.x_start;
    ent.y0       = in_i.y_start;
    ent.adx      = dx_abs[COORD_BITS-1:0];
    ent.ady      = dy_abs[COORD_BITS-1:0];
    ent.negx     = dx[COORD_BITS];
    ent.negy     = dy[COORD_BITS];
    ent.color    = in_i.color;
    // Step count is the major-axis length
    ent.steps    = (dx_abs > dy_abs) ? dx_abs[COORD_BITS-1:0] : dy_abs[COORD_BITS-1:0];
  end

  assign ent_o       = ent;
  assign ent_valid_o = in_i.valid;
  assign in_i.ready  = ent_ready_i;

endmodule

// ===== hw/rtl/dlr_queue.sv =====
// Two-entry queue decoupling the front end from the back end.
// No dependencies.
module dlr_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q, count_d;
  logic         push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ===== hw/rtl/dlr_back.sv =====
// Back end: runs queued entries, holds the line state, divides the deltas by
// the step count bit-serially and drives the registered pixel output.
// Depends on dlr_pkg and dlr_out_if.
module dlr_back #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned FRAC_BITS  = 16,
  localparam int unsigned EntryW = 5 * COORD_BITS + 3 + dlr_pkg::COLOR_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ent_valid_i,
  output logic              ent_ready_o,
  input  logic [EntryW-1:0] ent_i,
  dlr_out_if.source         out_o
);

  localparam int unsigned PosW = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned CntW = $clog2(FRAC_BITS + 2);
  localparam logic [CntW-1:0] LastCnt = CntW'(FRAC_BITS);

  typedef struct packed {
    logic                           is_start;
    logic [COORD_BITS-1:0]          x0;
    logic [COORD_BITS-1:0]          y0;
    logic [COORD_BITS-1:0]          adx;
    logic [COORD_BITS-1:0]          ady;
    logic [COORD_BITS-1:0]          steps;
    logic                           negx;
    logic                           negy;
    logic [dlr_pkg::COLOR_BITS-1:0] color;
  } entry_t;

  entry_t ent;
  assign ent = entry_t'(ent_i);

  dlr_pkg::bk_state_e state_q, state_d;

  // Line state; positions carry a +0.5 bias so the pixel is a plain slice
  logic [PosW-1:0]                 pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [PosW-1:0]                 step_x_q, step_x_d, step_y_q, step_y_d;
  logic [COORD_BITS-1:0]           steps_left_q, steps_left_d;
  logic [dlr_pkg::COLOR_BITS-1:0]  color_q, color_d;
  logic                            active_q, active_d;

  // Divider
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [COORD_BITS:0]   rx_q, rx_d, ry_q, ry_d;
  logic [COORD_BITS-1:0] rem_x, rem_y;
  logic [FRAC_BITS:0]    qx_q, qx_d, qy_q, qy_d;
  logic [COORD_BITS-1:0] div_q, div_d;
  logic                  negx_q, negx_d, negy_q, negy_d;
  logic                  bit_x, bit_y;

  // Output register
  logic                           ov_q, ov_d;
  logic                           res_q, res_d, last_q, last_d;
  logic [COORD_BITS-1:0]          px_q, px_d, py_q, py_d;
  logic [dlr_pkg::COLOR_BITS-1:0] pc_q, pc_d;

  logic out_free, take;
  logic [PosW-1:0] adv_x, adv_y, qx_ext, qy_ext;

  assign out_free    = !ov_q || out_o.ready;
  assign take        = ent_valid_i && (state_q == dlr_pkg::BK_RUN) && out_free;
  assign ent_ready_o = take;

  assign bit_x  = rx_q >= {1'b0, div_q};
  assign bit_y  = ry_q >= {1'b0, div_q};
  assign rem_x  = bit_x ? (rx_q[COORD_BITS-1:0] - div_q) : rx_q[COORD_BITS-1:0];
  assign rem_y  = bit_y ? (ry_q[COORD_BITS-1:0] - div_q) : ry_q[COORD_BITS-1:0];
  assign qx_d   = {qx_q[FRAC_BITS-1:0], bit_x};
  assign qy_d   = {qy_q[FRAC_BITS-1:0], bit_y};
  assign qx_ext = PosW'(qx_d);
  assign qy_ext = PosW'(qy_d);

  assign adv_x = pos_x_q + step_x_q;
  assign adv_y = pos_y_q + step_y_q;

  always_comb begin
    state_d      = state_q;
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    step_x_d     = step_x_q;
    step_y_d     = step_y_q;
    steps_left_d = steps_left_q;
    color_d      = color_q;
    active_d     = active_q;
    cnt_d        = cnt_q;
    rx_d         = {rem_x, 1'b0};
    ry_d         = {rem_y, 1'b0};
    div_d        = div_q;
    negx_d       = negx_q;
    negy_d       = negy_q;
    ov_d         = ov_q && !out_o.ready;
    res_d        = res_q;
    last_d       = last_q;
    px_d         = px_q;
    py_d         = py_q;
    pc_d         = pc_q;

    case (state_q)
      dlr_pkg::BK_RUN: begin
        if (take) begin
          ov_d = 1'b1;
          if (ent.is_start) begin
            pos_x_d = {1'b0, ent.x0, 1'b1, (FRAC_BITS-1)'(0)};
            pos_y_d = {1'b0, ent.y0, 1'b1, (FRAC_BITS-1)'(0)};
            color_d = ent.color;
            res_d   = 1'b1;
            px_d    = ent.x0;
            py_d    = ent.y0;
            pc_d    = ent.color;
            steps_left_d = ent.steps;
            step_x_d     = '0;
            step_y_d     = '0;
            if (ent.steps == '0) begin
              active_d = 1'b0;
              last_d   = 1'b1;
            end else begin
              // Start pixel goes out now; increments follow from the divider
              active_d = 1'b1;
              last_d   = 1'b0;
              state_d  = dlr_pkg::BK_DIV;
              cnt_d    = '0;
              rx_d     = {1'b0, ent.adx};
              ry_d     = {1'b0, ent.ady};
              div_d    = ent.steps;
              negx_d   = ent.negx;
              negy_d   = ent.negy;
            end
          end else if (!active_q) begin
            res_d  = 1'b0;
            last_d = 1'b0;
            px_d   = '0;
            py_d   = '0;
            pc_d   = '0;
          end else begin
            pos_x_d      = adv_x;
            pos_y_d      = adv_y;
            steps_left_d = steps_left_q - COORD_BITS'(1);
            res_d        = 1'b1;
            px_d         = adv_x[FRAC_BITS +: COORD_BITS];
            py_d         = adv_y[FRAC_BITS +: COORD_BITS];
            pc_d         = color_q;
            last_d       = (steps_left_q == COORD_BITS'(1));
            active_d     = (steps_left_q != COORD_BITS'(1));
          end
        end
      end
      dlr_pkg::BK_DIV: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == LastCnt) begin
          step_x_d = negx_q ? (PosW'(0) - qx_ext) : qx_ext;
          step_y_d = negy_q ? (PosW'(0) - qy_ext) : qy_ext;
          state_d  = dlr_pkg::BK_RUN;
        end
      end
      default: state_d = dlr_pkg::BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dlr_pkg::BK_RUN;
      steps_left_q <= '0;
      active_q     <= 1'b0;
      cnt_q        <= '0;
      ov_q         <= 1'b0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      step_x_q     <= '0;
      step_y_q     <= '0;
      color_q      <= '0;
    end else begin
      state_q      <= state_d;
      steps_left_q <= steps_left_d;
      active_q     <= active_d;
      cnt_q        <= cnt_d;
      ov_q         <= ov_d;
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      step_x_q     <= step_x_d;
      step_y_q     <= step_y_d;
      color_q      <= color_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    qx_q   <= qx_d;
    qy_q   <= qy_d;
    div_q  <= div_d;
    negx_q <= negx_d;
    negy_q <= negy_d;
    res_q  <= res_d;
    last_q <= last_d;
    px_q   <= px_d;
    py_q   <= py_d;
    pc_q   <= pc_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.valid_res   = res_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.pixel_color = pc_q;
  assign out_o.last        = last_q;

  a_no_take_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlr_pkg::BK_DIV) |-> !ent_ready_o)
    else $error("queue popped while divider busy");

  a_idle_no_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (steps_left_q == '0))
    else $error("steps left without an active line");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlr_pkg::BK_DIV && cnt_q == LastCnt) |=> (state_q == dlr_pkg::BK_RUN))
    else $error("divider overran its iteration count");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dlr_pkg::BK_DIV) |-> (cnt_q <= LastCnt))
    else $error("divider count out of range");

endmodule
